// ----- rtl/chd_pkg.sv -----
// ============================================================================
// chd_pkg
// Shared types and constants for the compass heading pipeline: axis and
// rotation payload structs, arctangent table and fixed angle constants.
// ============================================================================
`default_nettype none

package chd_pkg;

    // Angle accumulator fraction bits and table depth
    localparam int TABLE_FRAC = 24;
    localparam int TABLE_LEN  = 24;

    // Rotation vector and angle accumulator widths
    localparam int CX_W  = 43;
    localparam int ANG_W = 35;

    // Declination register reset value (6.63 degrees at 7 fraction bits)
    localparam logic signed [15:0] DECL_RESET = 16'sd849;

    // 180 degrees at TABLE_FRAC fraction bits
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(64'd180 << TABLE_FRAC);

    // atan(2^-i) in degrees, TABLE_FRAC fraction bits
    localparam logic [31:0] ATAN_DEG_Q24 [0:TABLE_LEN-1] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // Assembled sensor axes, carried alongside the angle computation
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_axes;

    // Vectoring state of one rotation stage
    typedef struct packed {
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic signed [ANG_W-1:0] ang;
        logic                    xneg;
        logic                    yneg;
    } t_cordic;

endpackage

`default_nettype wire

// ----- rtl/chd_cordic_stage.sv -----
// ============================================================================
// chd_cordic_stage
// One registered vectoring micro-rotation: drives the Y component toward
// zero and accumulates the matching arctangent step.
// ============================================================================
`default_nettype none

module chd_cordic_stage #(
    parameter int STAGE = 0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire chd_pkg::t_cordic  i_data,
    input  wire chd_pkg::t_axes    i_axes,
    output logic                   o_valid,
    output chd_pkg::t_cordic       o_data,
    output chd_pkg::t_axes         o_axes
);

    logic                                r_valid;
    chd_pkg::t_cordic                    r_data;
    chd_pkg::t_axes                      r_axes;
    chd_pkg::t_cordic                    n_data;
    logic signed [chd_pkg::CX_W-1:0]     dx;
    logic signed [chd_pkg::CX_W-1:0]     dy;
    logic signed [chd_pkg::ANG_W-1:0]    step_ang;

    // Shifted cross terms (floor shift) and this stage's angle step
    assign dx       = i_data.cy >>> STAGE;
    assign dy       = i_data.cx >>> STAGE;
    assign step_ang = $signed(chd_pkg::ANG_W'(chd_pkg::ATAN_DEG_Q24[5'(STAGE)]));

    // Rotate toward the X axis; no move when Y is already zero
    always_comb begin
        n_data = i_data;
        if (i_data.cy > 0) begin
            n_data.cx  = i_data.cx + dx;
            n_data.cy  = i_data.cy - dy;
            n_data.ang = i_data.ang + step_ang;
        end else if (i_data.cy < 0) begin
            n_data.cx  = i_data.cx - dx;
            n_data.cy  = i_data.cy + dy;
            n_data.ang = i_data.ang - step_ang;
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_axes <= i_axes;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_axes  = r_axes;

endmodule

`default_nettype wire

// ----- rtl/chd_heading_wrap.sv -----
// ============================================================================
// chd_heading_wrap
// Maps the first-quadrant angle to the full circle, rounds to the output
// precision, adds declination and reduces the sum into one turn.
// ============================================================================
`default_nettype none

module chd_heading_wrap #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire chd_pkg::t_cordic  i_data,
    input  wire chd_pkg::t_axes    i_axes,
    input  wire signed [15:0]      i_decl,
    output logic                   o_valid,
    output chd_pkg::t_axes         o_axes,
    output logic [15:0]            o_heading
);

    localparam int ANG_W      = chd_pkg::ANG_W;
    localparam int DROP       = chd_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int FULL_TURN  = 360 << ANGLE_FRAC_BITS;
    // Bound on |rounded heading + declination|
    localparam int MAX_MAG    = 32768 + (512 << ANGLE_FRAC_BITS);
    localparam int TURNS_BIAS = (MAX_MAG + FULL_TURN - 1) / FULL_TURN;
    localparam int RED_STEPS  = $clog2((2 * MAX_MAG) / FULL_TURN + 2);
    localparam int RED_W      = $clog2(FULL_TURN) + RED_STEPS + 2;

    localparam logic signed [ANG_W-1:0] HALF = ANG_W'(64'd1 << (DROP - 1));
    localparam logic [RED_W-1:0]        BIAS = RED_W'(TURNS_BIAS * FULL_TURN);
    localparam logic [RED_W-1:0]        TURN = RED_W'(FULL_TURN);

    logic [3:0]                 r_valid;
    chd_pkg::t_axes             r_axes [0:3];
    logic signed [ANG_W-1:0]    r_a;
    logic [RED_W-1:0]           r_h;
    logic [RED_W-1:0]           r_u;
    logic [RED_W-1:0]           r_red;

    logic                       neg_z;
    logic signed [ANG_W-1:0]    quad_off;
    logic signed [ANG_W-1:0]    n_a;
    logic signed [ANG_W-1:0]    rnd_sum;
    logic signed [ANG_W-1:0]    rnd_shift;
    logic [RED_W-1:0]           n_h;
    logic [RED_W-1:0]           n_u;
    logic [RED_W-1:0]           n_red;

    // Quadrant map: a, 180 - a, -a or a - 180 as one add with carry-in
    always_comb begin
        neg_z = i_data.xneg ^ i_data.yneg;
        if (!i_data.xneg) begin
            quad_off = '0;
        end else if (i_data.yneg) begin
            quad_off = -chd_pkg::ANG_180;
        end else begin
            quad_off = chd_pkg::ANG_180;
        end
        n_a = (neg_z ? ~i_data.ang : i_data.ang) + quad_off
            + $signed({{(ANG_W-1){1'b0}}, neg_z});
    end

    // Round half up to the output fraction bits
    always_comb begin
        rnd_sum   = r_a + HALF;
        rnd_shift = rnd_sum >>> DROP;
        n_h       = rnd_shift[RED_W-1:0];
    end

    // Add declination plus a whole number of turns to make the sum positive
    assign n_u = r_h + {{(RED_W-16){i_decl[15]}}, i_decl} + BIAS;

    // Strip turns by binary compare and subtract
    always_comb begin
        n_red = r_u;
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (n_red >= (TURN << k)) begin
                n_red = n_red - (TURN << k);
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_h       <= n_h;
        r_u       <= n_u;
        r_red     <= n_red;
        r_axes[0] <= i_axes;
        r_axes[1] <= r_axes[0];
        r_axes[2] <= r_axes[1];
        r_axes[3] <= r_axes[2];
    end

    assign o_valid   = r_valid[3];
    assign o_axes    = r_axes[3];
    assign o_heading = r_red[15:0];

endmodule

`default_nettype wire

// ----- rtl/compass_heading_from_magnetometer.sv -----
// A sample passes the input register, the rotator stages and the wrap registers before o_result_valid.
// Throughput: one sample per cycle; busy stays low, each vectoring rotation has its own stage.
// The result strobe lasts one cycle; results leave in input order.
// Reset (synchronous, active low) clears all valid bits and loads declination 849.
// Declination writes are taken at any time; write only while no sample is in flight.
// ============================================================================
// compass_heading_from_magnetometer
// Assembles X/Y/Z from raw bytes, computes atan2(Y, X) in degrees through a
// pipelined vectoring rotator, adds declination and wraps into one turn.
// ============================================================================
`default_nettype none

module compass_heading_from_magnetometer #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int ARCTAN_STAGES   = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire [7:0]          i_x_low_byte,
    input  wire [7:0]          i_x_high_byte,
    input  wire [7:0]          i_y_low_byte,
    input  wire [7:0]          i_y_high_byte,
    input  wire [7:0]          i_z_low_byte,
    input  wire [7:0]          i_z_high_byte,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire signed [15:0]  i_cfg_data,
    output logic               o_result_valid,
    output logic signed [15:0] o_x_axis,
    output logic signed [15:0] o_y_axis,
    output logic signed [15:0] o_z_axis,
    output logic [15:0]        o_heading_angle
);

    localparam int CX_W = chd_pkg::CX_W;

    logic signed [15:0]    r_decl;
    logic                  r_in_valid;
    chd_pkg::t_cordic      r_in_data;
    chd_pkg::t_axes        r_in_axes;

    chd_pkg::t_cordic      n_in_data;
    chd_pkg::t_axes        n_in_axes;
    logic signed [16:0]    x_ext;
    logic signed [16:0]    y_ext;
    logic signed [16:0]    x_abs;
    logic signed [16:0]    y_abs;

    logic                  w_valid [0:ARCTAN_STAGES];
    chd_pkg::t_cordic      w_data  [0:ARCTAN_STAGES];
    chd_pkg::t_axes        w_axes  [0:ARCTAN_STAGES];
    chd_pkg::t_axes        out_axes;

    // Never stalls
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Declination register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= chd_pkg::DECL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decl <= i_cfg_data;
        end
    end

    // Byte assembly, magnitudes and scaling into the rotator
    always_comb begin
        n_in_axes.x = $signed({i_x_high_byte, i_x_low_byte});
        n_in_axes.y = $signed({i_y_high_byte, i_y_low_byte});
        n_in_axes.z = $signed({i_z_high_byte, i_z_low_byte});
        x_ext = {n_in_axes.x[15], n_in_axes.x};
        y_ext = {n_in_axes.y[15], n_in_axes.y};
        x_abs = x_ext[16] ? -x_ext : x_ext;
        y_abs = y_ext[16] ? -y_ext : y_ext;
        n_in_data.cx   = $signed({{(CX_W-17-chd_pkg::TABLE_FRAC){1'b0}}, x_abs,
                                  {chd_pkg::TABLE_FRAC{1'b0}}});
        n_in_data.cy   = $signed({{(CX_W-17-chd_pkg::TABLE_FRAC){1'b0}}, y_abs,
                                  {chd_pkg::TABLE_FRAC{1'b0}}});
        n_in_data.ang  = '0;
        n_in_data.xneg = n_in_axes.x[15];
        n_in_data.yneg = n_in_axes.y[15];
    end

    // Input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        r_in_data <= n_in_data;
        r_in_axes <= n_in_axes;
    end

    assign w_valid[0] = r_in_valid;
    assign w_data[0]  = r_in_data;
    assign w_axes[0]  = r_in_axes;

    // Rotator chain, one micro-rotation per stage
    for (genvar g = 0; g < ARCTAN_STAGES; g++) begin : g_rot
        chd_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .i_axes  (w_axes[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .o_axes  (w_axes[g+1])
        );
    end

    // Quadrant map, rounding, declination and wrap
    chd_heading_wrap #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[ARCTAN_STAGES]),
        .i_data    (w_data[ARCTAN_STAGES]),
        .i_axes    (w_axes[ARCTAN_STAGES]),
        .i_decl    (r_decl),
        .o_valid   (o_result_valid),
        .o_axes    (out_axes),
        .o_heading (o_heading_angle)
    );

    assign o_x_axis = out_axes.x;
    assign o_y_axis = out_axes.y;
    assign o_z_axis = out_axes.z;

endmodule

`default_nettype wire
